// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/zcfm_pkg.sv =====
// ----------------------------------------------------------------------------
// zcfm_pkg
// Types and constants shared by the zero-crossing frequency meter modules.
// ----------------------------------------------------------------------------
package zcfm_pkg;

   // Register widths.
   localparam int OFFSET_BITS = 12;
   localparam int BAND_BITS   = 12;
   localparam int LIMIT_BITS  = 10;
   localparam int RATE_BITS   = 20;

   // Result field widths.
   localparam int FREQ_BITS     = 19;
   localparam int USED_BITS     = 10;
   localparam int RSP_DATA_BITS = 32;

   // Crossing counter and divider sizes.
   localparam int COUNT_BITS = 10;
   localparam int PROD_BITS  = RATE_BITS + COUNT_BITS;
   localparam int STEP_BITS  = $clog2(PROD_BITS);

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 20;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_LEVEL   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEAR_BAND      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CROSSING_LIMIT = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_RATE_HZ = 2'd3;

   // Register reset values.
   localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 12'd2110;
   localparam logic [BAND_BITS-1:0]   BAND_RESET   = 12'd320;
   localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 10'd1000;
   localparam logic [RATE_BITS-1:0]   RATE_RESET   = 20'd19048;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic sample_take;
      logic mul_go;
      logic div_step;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== rtl/zcfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// zcfm_ctrl
// Controller: takes samples, then sequences the multiply and the divide.
// ----------------------------------------------------------------------------
module zcfm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   output logic                req_tready,
   input  zcfm_pkg::status_type status,
   output zcfm_pkg::cmd_type    cmd
);

   zcfm_pkg::state_type              state_ff, state_in;
   logic [zcfm_pkg::STEP_BITS-1:0]   step_ff, step_in;

   // State and step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= zcfm_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         zcfm_pkg::ST_IDLE: begin
            if (req_tvalid && req_tlast) begin
               state_in = zcfm_pkg::ST_MUL;
            end
         end
         zcfm_pkg::ST_MUL: begin
            step_in  = '0;
            state_in = zcfm_pkg::ST_DIV;
         end
         zcfm_pkg::ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == zcfm_pkg::STEP_BITS'(zcfm_pkg::PROD_BITS - 1)) begin
               state_in = zcfm_pkg::ST_DONE;
            end
         end
         zcfm_pkg::ST_DONE: begin
            if (status.out_free) begin
               state_in = zcfm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = zcfm_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         zcfm_pkg::ST_IDLE: begin
            req_tready      = 1'b1;
            cmd.sample_take = req_tvalid;
         end
         zcfm_pkg::ST_MUL: begin
            cmd.mul_go = 1'b1;
         end
         zcfm_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         zcfm_pkg::ST_DONE: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/zcfm_dpath.sv =====
// ----------------------------------------------------------------------------
// zcfm_dpath
// Datapath: registers, crossing detection, multiplier, divider, output word.
// ----------------------------------------------------------------------------
module zcfm_dpath #(
   parameter int INDEX_BITS  = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [zcfm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [zcfm_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic [SAMPLE_BITS-1:0]                sample,
   input  logic                                  block_end,
   input  zcfm_pkg::cmd_type                     cmd,
   output zcfm_pkg::status_type                  status,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [zcfm_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic                                  rsp_tuser
);

   localparam int CMP_BITS = (SAMPLE_BITS > zcfm_pkg::OFFSET_BITS) ?
                             SAMPLE_BITS : zcfm_pkg::OFFSET_BITS;
   localparam int DEN_BITS = INDEX_BITS + 1;
   localparam int REM_BITS = INDEX_BITS + 2;
   localparam int PB       = zcfm_pkg::PROD_BITS;
   localparam int FB       = zcfm_pkg::FREQ_BITS;

   // Configuration registers.
   logic [zcfm_pkg::OFFSET_BITS-1:0] offset_ff;
   logic [zcfm_pkg::BAND_BITS-1:0]   band_ff;
   logic [zcfm_pkg::LIMIT_BITS-1:0]  limit_ff;
   logic [zcfm_pkg::RATE_BITS-1:0]   rate_ff;

   // Per-block state.
   logic                             was_above_ff;
   logic                             seen_first_ff;
   logic [INDEX_BITS-1:0]            idx_ff;
   logic [zcfm_pkg::COUNT_BITS-1:0]  count_ff;
   logic [INDEX_BITS-1:0]            first_ff;
   logic [INDEX_BITS-1:0]            latest_ff;
   logic [INDEX_BITS-1:0]            prev_ff;

   // Block-end operands and divider.
   logic                             pend_valid_ff;
   logic [zcfm_pkg::COUNT_BITS-1:0]  nm1_ff;
   logic [zcfm_pkg::USED_BITS-1:0]   used_ff;
   logic [DEN_BITS-1:0]              den_ff;
   logic [PB-1:0]                    num_ff;
   logic [REM_BITS-1:0]              rem_ff;

   // Output word.
   logic                             out_valid_ff;
   logic                             out_fvalid_ff;
   logic [FB-1:0]                    out_freq_ff;
   logic [zcfm_pkg::USED_BITS-1:0]   out_used_ff;

   // Crossing detection.
   logic [CMP_BITS-1:0]              smp_ext, off_ext, gap;
   logic                             above, hit;
   logic [zcfm_pkg::COUNT_BITS-1:0]  count_in;
   logic [INDEX_BITS-1:0]            first_in, latest_in, prev_in;
   logic [zcfm_pkg::COUNT_BITS-1:0]  n_even;
   logic [INDEX_BITS-1:0]            last_used, span;

   // Divider step and saturation.
   logic [REM_BITS-1:0]              trial;
   logic                             fits;
   logic [FB-1:0]                    freq_sat;

   always_comb begin
      smp_ext   = CMP_BITS'(sample);
      off_ext   = CMP_BITS'(offset_ff);
      above     = smp_ext > off_ext;
      gap       = above ? (smp_ext - off_ext) : (off_ext - smp_ext);
      hit       = seen_first_ff && (gap < CMP_BITS'(band_ff)) &&
                  (above != was_above_ff) &&
                  (count_ff < zcfm_pkg::COUNT_BITS'(limit_ff));
      count_in  = hit ? (count_ff + 1'b1) : count_ff;
      first_in  = (hit && (count_ff == '0)) ? idx_ff : first_ff;
      latest_in = hit ? idx_ff : latest_ff;
      prev_in   = hit ? latest_ff : prev_ff;
      // An odd count drops its last crossing.
      n_even    = {count_in[zcfm_pkg::COUNT_BITS-1:1], 1'b0};
      last_used = count_in[0] ? prev_in : latest_in;
      span      = last_used - first_in;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= zcfm_pkg::OFFSET_RESET;
         band_ff   <= zcfm_pkg::BAND_RESET;
         limit_ff  <= zcfm_pkg::LIMIT_RESET;
         rate_ff   <= zcfm_pkg::RATE_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            zcfm_pkg::CSR_OFFSET_LEVEL:
               offset_ff <= csr_wdata[zcfm_pkg::OFFSET_BITS-1:0];
            zcfm_pkg::CSR_NEAR_BAND:
               band_ff <= csr_wdata[zcfm_pkg::BAND_BITS-1:0];
            zcfm_pkg::CSR_CROSSING_LIMIT:
               limit_ff <= csr_wdata[zcfm_pkg::LIMIT_BITS-1:0];
            zcfm_pkg::CSR_SAMPLE_RATE_HZ:
               rate_ff <= csr_wdata[zcfm_pkg::RATE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Per-block state update; cleared after the last sample of a block.
   always_ff @(posedge clock) begin
      if (reset) begin
         was_above_ff  <= 1'b0;
         seen_first_ff <= 1'b0;
         idx_ff        <= '0;
         count_ff      <= '0;
         first_ff      <= '0;
         latest_ff     <= '0;
         prev_ff       <= '0;
      end else if (cmd.sample_take) begin
         if (block_end) begin
            was_above_ff  <= 1'b0;
            seen_first_ff <= 1'b0;
            idx_ff        <= '0;
            count_ff      <= '0;
            first_ff      <= '0;
            latest_ff     <= '0;
            prev_ff       <= '0;
         end else begin
            was_above_ff  <= above;
            seen_first_ff <= 1'b1;
            idx_ff        <= idx_ff + 1'b1;
            count_ff      <= count_in;
            first_ff      <= first_in;
            latest_ff     <= latest_in;
            prev_ff       <= prev_in;
         end
      end
   end

   // Block-end operands.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.sample_take && block_end) begin
         pend_valid_ff <= (n_even >= zcfm_pkg::COUNT_BITS'(2)) && (span != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sample_take && block_end) begin
         nm1_ff  <= n_even - 1'b1;
         used_ff <= n_even;
         den_ff  <= {span, 1'b0};
      end
   end

   // Restoring divider step: one quotient bit per cycle, shifted into num_ff.
   always_comb begin
      trial = {rem_ff[REM_BITS-2:0], num_ff[PB-1]};
      fits  = trial >= REM_BITS'(den_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_go) begin
         num_ff <= PB'(rate_ff * nm1_ff);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[PB-2:0], fits};
         rem_ff <= fits ? (trial - REM_BITS'(den_ff)) : trial;
      end
   end

   // Quotient saturates at the largest frequency code.
   assign freq_sat = (num_ff[PB-1:FB] != '0) ? '1 : num_ff[FB-1:0];

   // Output word register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_fvalid_ff <= pend_valid_ff;
         out_freq_ff   <= pend_valid_ff ? freq_sat : '0;
         out_used_ff   <= pend_valid_ff ? used_ff : '0;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tuser       = out_fvalid_ff;
   assign rsp_tdata       = zcfm_pkg::RSP_DATA_BITS'({out_used_ff, out_freq_ff});

endmodule

// ===== rtl/zero_crossing_frequency_meter_core.sv =====
// ----------------------------------------------------------------------------
// zero_crossing_frequency_meter_core
// Counts offset crossings over a block of ADC samples and reports frequency.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake          Content
//  req_*     in   tvalid/tready      sample word, tlast marks block end
//  rsp_*     out  tvalid/tready      one result word per block
//  csr_*     in   write enable only  four configuration registers
//
// Samples inside a block are taken one word per cycle.
// After the block-end word, req_tready stays low through the rate multiply,
// the bit-serial divider and the load of the result register.
// The result register holds its word until taken; a full one delays the load
// and the next block. Reset is synchronous and restores register defaults.
// ----------------------------------------------------------------------------
module zero_crossing_frequency_meter_core #(
   parameter int INDEX_BITS  = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Sample words.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,  // sample
   input  logic                                  req_tlast,  // block_end
   // Result words.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [zcfm_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // frequency_hz, crossings_used
   output logic                                  rsp_tuser,  // freq_valid
   // Configuration writes.
   input  logic                                  csr_wen,
   input  logic [zcfm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [zcfm_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   zcfm_pkg::cmd_type    cmd;
   zcfm_pkg::status_type status;

   // Controller.
   zcfm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath.
   zcfm_dpath #(
      .INDEX_BITS  (INDEX_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .sample     (req_tdata[SAMPLE_BITS-1:0]),
      .block_end  (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/zcfm_checker.sv =====
// ----------------------------------------------------------------------------
// zcfm_checker
// Port-level checks on the frequency meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zcfm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               req_tlast,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [zcfm_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                               rsp_tuser
);

   // A stalled result word holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // The block-end word starts the multiply and divide, so the next sample waits.
   `ASSERT_NEXT(a_end_stalls, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)

   // An invalid result carries an all-zero word.
   `ASSERT_SAME(a_invalid_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)

   // A valid result uses an even, nonzero crossing count.
   `ASSERT_SAME(a_valid_even, clock, reset, rsp_tvalid && rsp_tuser, !rsp_tdata[zcfm_pkg::FREQ_BITS] && (rsp_tdata[28:19] != '0))

endmodule

bind zero_crossing_frequency_meter_core zcfm_checker u_zcfm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== dv/zero_crossing_frequency_meter_core_tb.sv =====
// ----------------------------------------------------------------------------
// zero_crossing_frequency_meter_core_tb
// Self-checking bench for the zero-crossing frequency meter core. Sample
// words are streamed in blocks; an in-bench estimator tracks side changes
// near the offset line, predicts one result word per block, and a checker
// compares every result word against the oldest prediction.
// ----------------------------------------------------------------------------
module zero_crossing_frequency_meter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          SAMPLE_W     = 12;
   localparam int          INDEX_W      = 16;
   localparam int          REQ_DATA_W   = ((SAMPLE_W + 7) / 8) * 8;
   localparam int          FREQ_W       = zcfm_pkg::FREQ_BITS;
   localparam int          USED_W       = zcfm_pkg::USED_BITS;
   localparam int          RSP_W        = zcfm_pkg::RSP_DATA_BITS;
   localparam int          SETTLE_CYCLES = 40;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned FREQ_CEILING = 524287;

   // One predicted result word.
   typedef struct {
      bit              valid;
      bit [FREQ_W-1:0] freq;
      bit [USED_W-1:0] used;
   } freq_estimate_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [REQ_DATA_W-1:0]               req_tdata = '0;   // sample
   logic                                req_tlast = 1'b0; // block_end
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [RSP_W-1:0]                    rsp_tdata;        // frequency_hz, crossings_used
   logic                                rsp_tuser;        // freq_valid
   logic                                csr_wen = 1'b0;
   logic [zcfm_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [zcfm_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Register copies as the estimator sees them.
   logic [zcfm_pkg::OFFSET_BITS-1:0] cfg_offset = zcfm_pkg::OFFSET_RESET;
   logic [zcfm_pkg::BAND_BITS-1:0]   cfg_band   = zcfm_pkg::BAND_RESET;
   logic [zcfm_pkg::LIMIT_BITS-1:0]  cfg_limit  = zcfm_pkg::LIMIT_RESET;
   logic [zcfm_pkg::RATE_BITS-1:0]   cfg_rate   = zcfm_pkg::RATE_RESET;

   // Per-block crossing state of the estimator.
   bit                               was_above   = 1'b0;
   bit                               seen_first  = 1'b0;
   logic [INDEX_W-1:0]               sample_idx  = '0;
   logic [zcfm_pkg::COUNT_BITS-1:0]  cross_count = '0;
   logic [INDEX_W-1:0]               first_idx   = '0;
   logic [INDEX_W-1:0]               last_idx    = '0;
   logic [INDEX_W-1:0]               prev_idx    = '0;

   freq_estimate_type expected_freqs[$];
   freq_estimate_type oldest_estimate;
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count = 0;
   int unsigned       idle_pct = 0;
   int unsigned       stall_pct = 0;

   zero_crossing_frequency_meter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Result-side back-pressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // Advance the crossing state by one accepted sample word. Returns 1 and
   // fills the estimate when the word closes a block.
   function automatic bit estimate_frequency(input logic [SAMPLE_W-1:0] smp,
                                             input bit last,
                                             output freq_estimate_type est);
      bit                              above;
      logic [SAMPLE_W-1:0]             gap;
      logic [zcfm_pkg::COUNT_BITS-1:0] n;
      logic [INDEX_W-1:0]              end_idx;
      logic [INDEX_W-1:0]              span;
      longint unsigned                 quotient;
      above = smp > cfg_offset;
      est = '{1'b0, '0, '0};
      if (!seen_first) begin
         seen_first = 1'b1;
      end else begin
         gap = above ? smp - cfg_offset : cfg_offset - smp;
         if (gap < cfg_band && above != was_above && cross_count < cfg_limit) begin
            if (cross_count == 0) first_idx = sample_idx;
            prev_idx = last_idx;
            last_idx = sample_idx;
            cross_count = cross_count + 1'b1;
         end
      end
      was_above = above;
      sample_idx = sample_idx + 1'b1;
      if (!last) return 1'b0;

      // An odd count drops its last crossing before the rate is worked out.
      n = cross_count;
      end_idx = last_idx;
      if (n[0]) begin
         n = n - 1'b1;
         end_idx = prev_idx;
      end
      if (n >= 2) begin
         span = end_idx - first_idx;
         if (span != 0) begin
            quotient = (64'(cfg_rate) * 64'(n - 1'b1)) / (64'(span) * 64'd2);
            est.valid = 1'b1;
            est.freq = (quotient > FREQ_CEILING) ? FREQ_W'(FREQ_CEILING) :
                                                   quotient[FREQ_W-1:0];
            est.used = n;
         end
      end
      was_above = 1'b0;
      seen_first = 1'b0;
      sample_idx = '0;
      cross_count = '0;
      first_idx = '0;
      last_idx = '0;
      prev_idx = '0;
      return 1'b1;
   endfunction

   // Compare each accepted result word with the oldest estimate.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_freqs.size() == 0) begin
            report_mismatch("unexpected result word", rsp_tdata, 0);
         end else begin
            oldest_estimate = expected_freqs.pop_front();
            if (rsp_tuser !== oldest_estimate.valid)
               report_mismatch("freq_valid", 32'(rsp_tuser), 32'(oldest_estimate.valid));
            if (rsp_tdata[FREQ_W-1:0] !== oldest_estimate.freq)
               report_mismatch("frequency_hz", 32'(rsp_tdata[FREQ_W-1:0]),
                               32'(oldest_estimate.freq));
            if (rsp_tdata[FREQ_W+USED_W-1:FREQ_W] !== oldest_estimate.used)
               report_mismatch("crossings_used", 32'(rsp_tdata[FREQ_W+USED_W-1:FREQ_W]),
                               32'(oldest_estimate.used));
            if (rsp_tdata[RSP_W-1:FREQ_W+USED_W] !== '0)
               report_mismatch("result padding", 32'(rsp_tdata[RSP_W-1:FREQ_W+USED_W]),
                               0);
         end
      end
   end

   // Offer one sample word, with random idle cycles ahead of it, and record
   // its effect once the core takes it.
   task automatic send_word(input logic [SAMPLE_W-1:0] smp, input bit last);
      freq_estimate_type est;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(smp);
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (estimate_frequency(smp, last, est)) expected_freqs.push_back(est);
   endtask

   // Stop sending and hold off until every result word has come back and
   // the divider has had time to finish.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_freqs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [zcfm_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [zcfm_pkg::CSR_DATA_BITS-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         zcfm_pkg::CSR_OFFSET_LEVEL:   cfg_offset = value[zcfm_pkg::OFFSET_BITS-1:0];
         zcfm_pkg::CSR_NEAR_BAND:      cfg_band   = value[zcfm_pkg::BAND_BITS-1:0];
         zcfm_pkg::CSR_CROSSING_LIMIT: cfg_limit  = value[zcfm_pkg::LIMIT_BITS-1:0];
         zcfm_pkg::CSR_SAMPLE_RATE_HZ: cfg_rate   = value[zcfm_pkg::RATE_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   // A block that swings around the offset line, changing side every
   // half samples and starting below. A rough block scatters the distance
   // to the line, sometimes past the band, and drops in a stray sample.
   task automatic send_wave_block(input int len, input int half, input bit rough);
      int val;
      int gap;
      bit up;
      for (int i = 0; i < len; i++) begin
         up = ((i / half) % 2) == 1;
         gap = rough ? $urandom_range(int'(cfg_band) + int'(cfg_band) / 2 + 2) : 0;
         val = up ? int'(cfg_offset) + gap + 1 : int'(cfg_offset) - gap;
         if (rough && $urandom_range(15) == 0) val = $urandom_range(4095);
         if (val < 0) val = 0;
         if (val > 4095) val = 4095;
         send_word(SAMPLE_W'(val), i == len - 1);
      end
   endtask

   // Registers at their reset values: five crossings, the odd one dropped.
   task automatic test_reset_values();
      send_word(12'd0, 1'b0);
      send_word(12'd2200, 1'b0);
      send_word(12'd2000, 1'b0);
      send_word(12'd2300, 1'b0);
      send_word(12'd4095, 1'b0);
      send_word(12'd2100, 1'b0);
      send_word(12'd2111, 1'b1);
   endtask

   // A block of one word, then a block with a single crossing.
   task automatic test_short_blocks();
      send_word(12'd3000, 1'b1);
      send_wave_block(2, 1, 1'b0);
   endtask

   // Rate and band at their maximum, a crossing limit of two with a zero
   // rate, a zero band, and crossing limits that cannot hold two crossings.
   task automatic test_register_extremes();
      wait_idle();
      write_reg(zcfm_pkg::CSR_OFFSET_LEVEL, 20'd2048);
      write_reg(zcfm_pkg::CSR_NEAR_BAND, 20'd4095);
      write_reg(zcfm_pkg::CSR_CROSSING_LIMIT, 20'd1023);
      write_reg(zcfm_pkg::CSR_SAMPLE_RATE_HZ, 20'hFFFFF);
      send_wave_block(4, 1, 1'b0);
      wait_idle();
      write_reg(zcfm_pkg::CSR_CROSSING_LIMIT, 20'd2);
      write_reg(zcfm_pkg::CSR_SAMPLE_RATE_HZ, 20'd0);
      send_wave_block(5, 1, 1'b0);
      wait_idle();
      write_reg(zcfm_pkg::CSR_NEAR_BAND, 20'd0);
      write_reg(zcfm_pkg::CSR_CROSSING_LIMIT, 20'd1023);
      send_wave_block(3, 1, 1'b0);
      wait_idle();
      write_reg(zcfm_pkg::CSR_NEAR_BAND, 20'd4095);
      write_reg(zcfm_pkg::CSR_CROSSING_LIMIT, 20'd0);
      send_wave_block(3, 1, 1'b0);
      wait_idle();
      write_reg(zcfm_pkg::CSR_CROSSING_LIMIT, 20'd1);
      send_wave_block(3, 1, 1'b0);
   endtask

   // Pick a register setting, extremes included; unused upper write bits
   // carry junk that the core must ignore.
   task automatic set_random_registers();
      logic [31:0]                      junk;
      logic [zcfm_pkg::OFFSET_BITS-1:0] off;
      logic [zcfm_pkg::BAND_BITS-1:0]   band;
      logic [zcfm_pkg::LIMIT_BITS-1:0]  lim;
      logic [zcfm_pkg::RATE_BITS-1:0]   rate;
      junk = $urandom;
      case ($urandom_range(9))
         0:       off = '0;
         1:       off = '1;
         2:       off = zcfm_pkg::OFFSET_BITS'($urandom_range(4095));
         default: off = zcfm_pkg::OFFSET_BITS'($urandom_range(1024, 3072));
      endcase
      case ($urandom_range(9))
         0:       band = '0;
         1:       band = '1;
         2:       band = 12'd1;
         default: band = zcfm_pkg::BAND_BITS'($urandom_range(2, 600));
      endcase
      case ($urandom_range(9))
         0:       lim = zcfm_pkg::LIMIT_BITS'($urandom_range(1));
         1:       lim = '1;
         2, 3:    lim = zcfm_pkg::LIMIT_BITS'($urandom_range(2, 6));
         default: lim = zcfm_pkg::LIMIT_BITS'($urandom_range(7, 1022));
      endcase
      case ($urandom_range(9))
         0:       rate = '0;
         1:       rate = 20'd1;
         2:       rate = '1;
         3:       rate = zcfm_pkg::RATE_BITS'($urandom);
         default: rate = zcfm_pkg::RATE_BITS'($urandom_range(1000, 200000));
      endcase
      write_reg(zcfm_pkg::CSR_OFFSET_LEVEL, {junk[7:0], off});
      write_reg(zcfm_pkg::CSR_NEAR_BAND, {junk[15:8], band});
      write_reg(zcfm_pkg::CSR_CROSSING_LIMIT, {junk[25:16], lim});
      write_reg(zcfm_pkg::CSR_SAMPLE_RATE_HZ, rate);
   endtask

   // Mostly swinging blocks of random shape, the rest raw noise, under
   // three register settings per phase.
   task automatic test_random_traffic(input int unsigned sender_idle,
                                      input int unsigned receiver_stall,
                                      input int words);
      int sent;
      int len;
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      for (int setting = 0; setting < 3; setting++) begin
         wait_idle();
         set_random_registers();
         sent = 0;
         while (sent < words / 3) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 80) : $urandom_range(2, 16);
            if ($urandom_range(9) < 8) begin
               send_wave_block(len, $urandom_range(1, 4), 1'b1);
            end else begin
               len = $urandom_range(1, 12);
               for (int i = 0; i < len; i++)
                  send_word(SAMPLE_W'($urandom), i == len - 1);
            end
            sent += len;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_short_blocks();
      test_register_extremes();
      test_random_traffic(0, 0, 100);
      test_random_traffic(87, 0, 100);
      test_random_traffic(0, 87, 100);
      test_random_traffic(36, 36, 100);
      wait_idle();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
